FILE: rtl/nqts_pkg.sv
// Shared types and constants for the note queue tone sequencer.
`default_nettype none

package nqts_pkg;

    // Item operation codes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam int FREQ_W  = 16;
    localparam int LEN_W   = 12;
    localparam int DIV_W   = 8;
    localparam int DELTA_W = 16;
    localparam int ELAP_W  = 26;
    localparam int THR_W   = 2 * LEN_W;

    localparam logic [LEN_W-1:0] BASE_LEN_RST = 12'd800;

    // One quotient bit per cycle in the length divider
    localparam int DIV_STEPS = LEN_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    typedef struct packed {
        logic [1:0]         op;
        logic [FREQ_W-1:0]  tone_freq;
        logic [DIV_W-1:0]   duration_div;
        logic [DELTA_W-1:0] delta;
    } t_item;

    typedef struct packed {
        logic              tone_start;
        logic              tone_on;
        logic [FREQ_W-1:0] tone_freq_out;
        logic [LEN_W-1:0]  tone_ms;
        logic              queue_empty;
        logic              dropped;
    } t_result;

    typedef enum logic [1:0] {
        PH_WAIT  = 2'd0,
        PH_START = 2'd1,
        PH_PLAY  = 2'd2,
        PH_PAUSE = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_DIV,
        S_MUL,
        S_SCALE,
        S_UPD,
        S_DONE
    } t_ctl_state;

    typedef struct packed {
        logic capture;
        logic rd_en;
        logic div_init;
        logic div_step;
        logic mul;
        logic scale;
        logic update;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       div_last;
    } t_dp_sts;

endpackage

`default_nettype wire

FILE: rtl/nqts_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module nqts_ram #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/nqts_ctrl.sv
// Controller state machine that sequences one item through the datapath.
`default_nettype none

module nqts_ctrl
    import nqts_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_start,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd,
    output logic         o_busy,
    output logic         o_valid
);

    t_ctl_state r_state;
    t_ctl_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        o_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd_en    = 1'b1;
                o_cmd.div_init = 1'b1;
                case (i_sts.op)
                    OP_ADD:  n_state = S_DIV;
                    OP_TICK: n_state = S_MUL;
                    default: n_state = S_UPD;
                endcase
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_UPD;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = S_UPD;
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                o_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/nqts_dpath.sv
// Datapath: note store, length divider, threshold multiply and play state.
`default_nettype none

module nqts_dpath
    import nqts_pkg::*;
#(
    parameter int NOTE_SLOTS = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [LEN_W-1:0] i_cfg_data,
    input  wire t_item            i_item,
    input  wire t_dp_cmd          i_cmd,
    output t_dp_sts               o_sts,
    output t_result               o_result
);

    localparam int IW    = $clog2(NOTE_SLOTS);
    localparam int CW    = $clog2(NOTE_SLOTS + 1);
    localparam int MEM_W = FREQ_W + LEN_W;

    // Configuration and captured item
    logic [LEN_W-1:0] r_note_len;
    t_item            r_item;

    // Play state
    t_phase             r_phase, n_phase;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_play_idx, n_play_idx;
    logic [ELAP_W-1:0]  r_elapsed, n_elapsed;
    logic               r_sounding, n_sounding;
    logic               r_start, n_start;
    logic               r_drop, n_drop;

    // Divider
    logic [DIV_W-1:0]   r_divisor;
    logic [DIV_W-1:0]   r_rem;
    logic [LEN_W-1:0]   r_quot;
    logic [DCNT_W-1:0]  r_div_cnt;
    logic [DIV_W:0]     w_shift;
    logic               w_ge;

    // Thresholds
    logic [THR_W-1:0]    r_thr;
    logic [ELAP_W+3:0]   r_e10;
    logic [THR_W+3:0]    r_t13;

    // Store access
    logic [MEM_W-1:0]  w_rdata;
    logic [FREQ_W-1:0] w_rd_freq;
    logic [LEN_W-1:0]  w_rd_len;
    logic              w_full;
    logic              w_empty;
    logic              w_we;
    logic [ELAP_W:0]   w_sum;
    logic [ELAP_W-1:0] w_elap_add;

    assign w_rd_freq = w_rdata[MEM_W-1:LEN_W];
    assign w_rd_len  = w_rdata[LEN_W-1:0];
    assign w_full    = (r_count == CW'(NOTE_SLOTS));
    assign w_empty   = (r_play_idx == r_count);
    assign w_we      = i_cmd.update && (r_item.op == OP_ADD) && !w_full;

    // Saturating elapsed-time add
    assign w_sum      = {1'b0, r_elapsed} + (ELAP_W + 1)'(r_item.delta);
    assign w_elap_add = w_sum[ELAP_W] ? {ELAP_W{1'b1}} : w_sum[ELAP_W-1:0];

    // Note store: frequency and length per slot
    nqts_ram #(
        .WIDTH (MEM_W),
        .DEPTH (NOTE_SLOTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[IW-1:0]),
        .i_wdata ({r_item.tone_freq, r_quot}),
        .i_re    (i_cmd.rd_en),
        .i_raddr (r_play_idx[IW-1:0]),
        .o_rdata (w_rdata)
    );

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_note_len <= BASE_LEN_RST;
        end else if (i_cfg_we) begin
            r_note_len <= i_cfg_data;
        end
    end

    // Capture the item beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_item;
        end
    end

    // Restoring divider: base length / divisor, one bit per cycle
    assign w_shift = {r_rem, r_quot[LEN_W-1]};
    assign w_ge    = (w_shift >= {1'b0, r_divisor});

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_divisor <= (r_item.duration_div == '0) ? DIV_W'(1) : r_item.duration_div;
            r_rem     <= '0;
            r_quot    <= r_note_len;
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem     <= w_ge ? DIV_W'(w_shift - {1'b0, r_divisor}) : w_shift[DIV_W-1:0];
            r_quot    <= {r_quot[LEN_W-2:0], w_ge};
            r_div_cnt <= r_div_cnt + DCNT_W'(1);
        end
    end

    // Threshold = note length times stored length, then scale both sides
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_thr <= {{LEN_W{1'b0}}, w_rd_len} * {{LEN_W{1'b0}}, r_note_len};
        end
        if (i_cmd.scale) begin
            r_e10 <= ({4'b0, r_elapsed} << 3) + ({4'b0, r_elapsed} << 1);
            r_t13 <= ({4'b0, r_thr} << 3) + ({4'b0, r_thr} << 2) + {4'b0, r_thr};
        end
    end

    // Next play state for the item
    always_comb begin
        n_phase    = r_phase;
        n_count    = r_count;
        n_play_idx = r_play_idx;
        n_elapsed  = r_elapsed;
        n_sounding = r_sounding;
        n_start    = r_start;
        n_drop     = r_drop;
        if (i_cmd.update) begin
            n_start = 1'b0;
            n_drop  = 1'b0;
            case (r_item.op)
                OP_CLEAR: begin
                    n_count    = '0;
                    n_play_idx = '0;
                    n_elapsed  = '0;
                    n_sounding = 1'b0;
                    n_phase    = PH_START;
                end
                OP_ADD: begin
                    if (w_full) begin
                        n_drop = 1'b1;
                    end else begin
                        n_count = r_count + CW'(1);
                        if (r_phase == PH_WAIT) begin
                            n_phase = PH_START;
                        end
                    end
                end
                OP_TICK: begin
                    if (r_phase != PH_WAIT) begin
                        if (w_empty) begin
                            n_phase = PH_WAIT;
                        end else begin
                            case (r_phase)
                                PH_START: begin
                                    n_start    = 1'b1;
                                    n_sounding = 1'b1;
                                    n_phase    = PH_PLAY;
                                    n_elapsed  = '0;
                                end
                                PH_PLAY: begin
                                    if (r_elapsed >= ELAP_W'(r_thr)) begin
                                        n_phase    = PH_PAUSE;
                                        n_sounding = 1'b0;
                                        n_elapsed  = '0;
                                    end else begin
                                        n_elapsed = w_elap_add;
                                    end
                                end
                                default: begin
                                    if (r_e10 >= (ELAP_W + 4)'(r_t13)) begin
                                        n_play_idx = r_play_idx + CW'(1);
                                        n_phase    = PH_START;
                                    end else begin
                                        n_elapsed = w_elap_add;
                                    end
                                end
                            endcase
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Play state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_WAIT;
            r_count    <= '0;
            r_play_idx <= '0;
            r_elapsed  <= '0;
            r_sounding <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_count    <= n_count;
            r_play_idx <= n_play_idx;
            r_elapsed  <= n_elapsed;
            r_sounding <= n_sounding;
        end
    end

    // Per-item flags
    always_ff @(posedge i_clk) begin
        r_start <= n_start;
        r_drop  <= n_drop;
    end

    // Status back to the controller
    assign o_sts.op       = r_item.op;
    assign o_sts.div_last = (r_div_cnt == DCNT_W'(DIV_STEPS - 1));

    // Result beat
    assign o_result.tone_start    = r_start;
    assign o_result.tone_on       = r_sounding;
    assign o_result.tone_freq_out = r_sounding ? w_rd_freq : '0;
    assign o_result.tone_ms       = r_sounding ? w_rd_len : '0;
    assign o_result.queue_empty   = w_empty;
    assign o_result.dropped       = r_drop;

endmodule

`default_nettype wire

FILE: rtl/note_queue_tone_sequencer_core.sv
// Top level of the note queue tone sequencer: controller, datapath and checks.
`default_nettype none

// Items are taken one at a time: start is accepted while busy is low, and the
// result beat appears on o_result for exactly one cycle with o_valid high; the
// receiver cannot stall it. Each item runs to its end before the next accept:
// a clear or an unused op does store read and update; a tick does store read,
// threshold multiply, scaling and update; an add puts the restoring divider,
// forming the note length one quotient bit per cycle, before the update.
// Write the base length through i_cfg_we/i_cfg_data only while busy is low.
module note_queue_tone_sequencer_core
    import nqts_pkg::*;
#(
    parameter int NOTE_SLOTS = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [LEN_W-1:0] i_cfg_data,
    input  wire logic             start,
    input  wire t_item            i_item,
    output logic                  busy,
    output logic                  o_valid,
    output t_result               o_result
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // Sequencing
    nqts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    // Store and arithmetic
    nqts_dpath #(
        .NOTE_SLOTS (NOTE_SLOTS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_item),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_result   (o_result)
    );

`ifndef SYNTHESIS
    a_valid_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result beat outside an item");

    a_accept_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_start_sounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.tone_start) |-> o_result.tone_on)
        else $error("note start without tone on");

    a_silent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.tone_on) |->
            (o_result.tone_freq_out == '0) && (o_result.tone_ms == '0))
        else $error("silent result carries note data");
`endif

endmodule

`default_nettype wire
